### design/oale_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oale_pkg
// Shared sizes, operation and status codes and the result beat type of the
// ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // compare width that holds the position, the count and count + 1
    localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam int WORD_W = 32;
    localparam int FUNC_W = 2;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 8;

    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LOCATE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] result_value;
        logic [LEN_W-1:0]         list_length;
        logic                     list_empty;
    } rsp_beat_t;

endpackage

`default_nettype wire

### design/oale_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oale request and response channels
// Valid/ready channels that carry one request beat and one result beat.
// ----------------------------------------------------------------------------
interface oale_req_if import oale_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output func, output position, output item_value,
                    input ready);
    modport sink   (input valid, input func, input position, input item_value,
                    output ready);

endinterface

interface oale_rsp_if import oale_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] result_value;
    logic [LEN_W-1:0]         list_length;
    logic                     list_empty;

    modport source (output valid, output status, output result_value,
                    output list_length, output list_empty, input ready);
    modport sink   (input valid, input status, input result_value,
                    input list_length, input list_empty, output ready);

endinterface

`default_nettype wire

### design/oale_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oale_out_buf
// One-entry output register that holds a finished result beat until the
// receiver takes it, so the engine can start the next request meanwhile.
// ----------------------------------------------------------------------------
module oale_out_buf import oale_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  rsp_beat_t  push_data,
    output logic       push_ready,
    oale_rsp_if.source rsp
);

    logic      full_reg;
    rsp_beat_t beat_reg;

    assign push_ready = !full_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (push)
        begin
            full_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            beat_reg <= push_data;
        end
    end

    assign rsp.valid        = full_reg;
    assign rsp.status       = beat_reg.status;
    assign rsp.result_value = beat_reg.result_value;
    assign rsp.list_length  = beat_reg.list_length;
    assign rsp.list_empty   = beat_reg.list_empty;

endmodule

`default_nettype wire

### design/ordered_array_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Sequential list of signed 32-bit words kept in one synchronous memory.
//
// req carries one request beat (func, position, item_value); rsp returns
// exactly one result beat per request (status, result_value, list_length,
// list_empty). Clear empties the list, insert and delete work at a 1-based
// position and move the later entries, locate returns the first matching
// index.
// Each request is handled alone. The memory has one read and one write port
// with a registered read; shifts and searches stream one entry per cycle,
// reading the next entry while the previous one is written back or compared.
// Clear and refused requests go straight to the result; insert shifts the
// entries from the tail down to the position, append writes at the tail,
// delete shifts the entries after the position down, locate stops at the
// first hit or after the last entry. A new request is taken in the cycle
// after the result is handed to the output register.
// A result waits in the output register while rsp is stalled; the engine
// stays busy only if a second result is finished before the first is taken.
// Reset empties the list; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit import oale_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    oale_req_if.sink   req,
    oale_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_FIND,
        S_PUT,
        S_RESP
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     issue_reg, issue_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]         end_reg, end_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic signed [WORD_W-1:0] value_reg, value_next;

    logic signed [WORD_W-1:0] mem [CAPACITY];
    logic signed [WORD_W-1:0] rd_data_reg;

    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] cnt_last;
    logic             ins_pos_ok;
    logic             del_pos_ok;
    logic             is_full;
    logic             accept;
    logic             last_rd;
    logic             hit;
    logic             push;
    logic             push_ready;
    rsp_beat_t        push_data;

    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_ext    = CMP_W'(req.position);
    assign pos_idx    = IDX_W'(pos_ext - CMP_W'(1));
    assign cnt_last   = IDX_W'(count_reg - CNT_W'(1));
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign is_full    = cnt_ext >= CMP_W'(CAPACITY);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rd_en   = issue_reg && ((state_reg == S_UP) || (state_reg == S_DOWN) ||
                                   (state_reg == S_FIND));
    assign last_rd = (addr_reg == end_reg);
    assign hit     = rd_vld_reg && (rd_data_reg == word_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        status_next = status_reg;
        value_next  = value_reg;
        rd_vld_next = rd_en;
        rd_idx_next = rd_en ? addr_reg : rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = rd_idx_reg;
        wr_data     = rd_data_reg;
        push        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next   = req.item_value;
                    pos_next    = pos_idx;
                    status_next = ST_OK;
                    value_next  = '0;
                    state_next  = S_RESP;
                    unique case (req.func)
                        FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        FN_INSERT:
                        begin
                            priority if (!ins_pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext == cnt_ext + CMP_W'(1))
                            begin
                                // append: nothing to move
                                state_next = S_PUT;
                            end
                            else
                            begin
                                addr_next  = cnt_last;
                                end_next   = pos_idx;
                                issue_next = 1'b1;
                                state_next = S_UP;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!del_pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                addr_next  = pos_idx;
                                end_next   = cnt_last;
                                issue_next = 1'b1;
                                state_next = S_DOWN;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                addr_next  = '0;
                                end_next   = cnt_last;
                                issue_next = 1'b1;
                                state_next = S_FIND;
                            end
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // walk down from the tail, each word moves one slot up
                if (issue_reg)
                begin
                    addr_next = addr_reg - IDX_W'(1);
                    if (last_rd)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + IDX_W'(1);
                end
                if (!issue_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = word_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end
            S_DOWN:
            begin
                // first word read is the one removed, the rest move one slot down
                if (issue_reg)
                begin
                    addr_next = addr_reg + IDX_W'(1);
                    if (last_rd)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == pos_reg)
                    begin
                        value_next = rd_data_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg - IDX_W'(1);
                    end
                end
                if (!issue_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end
            S_FIND:
            begin
                if (issue_reg)
                begin
                    addr_next = addr_reg + IDX_W'(1);
                    if (last_rd)
                    begin
                        issue_next = 1'b0;
                    end
                end
                priority if (hit)
                begin
                    // a read still in flight is dropped
                    status_next = ST_OK;
                    value_next  = WORD_W'(rd_idx_reg);
                    issue_next  = 1'b0;
                    state_next  = S_RESP;
                end
                else if (!issue_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                // hand over only when the output register can take the beat
                if (push_ready)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issue_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        end_reg    <= end_next;
        pos_reg    <= pos_next;
        rd_idx_reg <= rd_idx_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign push_data.status       = status_reg;
    assign push_data.result_value = value_reg;
    assign push_data.list_length  = LEN_W'(count_reg);
    assign push_data.list_empty   = (count_reg == '0);

    oale_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .rsp        (rsp)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("accepted request did not start");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && rd_en |-> wr_addr != addr_reg)
        else $error("read and write hit the same entry");

    a_tail_data_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UP) || (state_reg == S_DOWN) || (state_reg == S_FIND))
        && !issue_reg |-> rd_vld_reg)
        else $error("scan finished without its last read data");

    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");
`endif

endmodule

`default_nettype wire

### verif/list_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// Watches the request and result channels of the ordered array list engine.
// Every accepted request beat runs through a behavioral copy of the list,
// which gives the expected result beat. Every accepted result beat is
// compared field by field with the oldest expected beat still waiting.
// ----------------------------------------------------------------------------
module list_result_checker import oale_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    oale_req_if  req,
    oale_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len;
    rsp_beat_t                expected_beats [$];
    int                       mismatch_count;

    assign fail_count = mismatch_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 50)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // list behavior: updates the copy of the list and returns the result beat
    function automatic rsp_beat_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                input logic [POS_W-1:0] p,
                                                input logic signed [WORD_W-1:0] v);
        rsp_beat_t r;
        int        pos;
        int        i;
        bit        found;
        r.status       = ST_OK;
        r.result_value = '0;
        pos            = int'(p);
        found          = 1'b0;
        case (f)
            FN_CLEAR:
            begin
                list_len = 0;
            end
            FN_INSERT:
            begin
                // position is checked before fullness
                if (pos < 1 || pos > list_len + 1)
                    r.status = ST_BADPOS;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i >= pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos-1] = v;
                    list_len++;
                end
            end
            FN_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    r.status = ST_BADPOS;
                else
                begin
                    r.result_value = list_words[pos-1];
                    for (i = pos; i < list_len; i++)
                        list_words[i-1] = list_words[i];
                    list_len--;
                end
            end
            default:
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < list_len && !found; i++)
                begin
                    if (list_words[i] == v)
                    begin
                        found          = 1'b1;
                        r.status       = ST_OK;
                        r.result_value = WORD_W'(i);
                    end
                end
            end
        endcase
        r.list_length = LEN_W'(list_len);
        r.list_empty  = (list_len == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            list_len = 0;
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            // result side first: a result can never belong to a request of this edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with nothing expected", rsp.status, -1);
                else
                begin
                    want = expected_beats.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.result_value !== want.result_value)
                        report_mismatch("result_value", rsp.result_value, want.result_value);
                    if (rsp.list_length !== want.list_length)
                        report_mismatch("list_length", rsp.list_length, want.list_length);
                    if (rsp.list_empty !== want.list_empty)
                        report_mismatch("list_empty", rsp.list_empty, want.list_empty);
                end
            end
            if (req.valid && req.ready)
                expected_beats.push_back(apply_list_op(req.func, req.position, req.item_value));
            pending <= expected_beats.size();
        end
    end

    initial mismatch_count = 0;

endmodule

### verif/ordered_array_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit_tb
// Drives requests into the ordered array list engine: a short directed run
// over the refusal, edge and duplicate cases, a fill to full capacity, then
// random grow and shrink phases with noise, random idling on both channels,
// one long result hold-off and drain pauses. The checker beside the block
// predicts and compares; this module only gives the verdict.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit_tb import oale_pkg::*;
;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   shadow_len;
    bit   quiet;
    bit   hold_request;
    logic signed [WORD_W-1:0] value_pool [16];

    oale_req_if req_if ();
    oale_rsp_if rsp_if ();

    ordered_array_list_engine_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_result_checker results_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // length as the sender sees it, only to aim positions
    task automatic track_length(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p);
        case (f)
            FN_CLEAR:
                shadow_len = 0;
            FN_INSERT:
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY)
                    shadow_len++;
            FN_DELETE:
                if (p >= 1 && p <= shadow_len)
                    shadow_len--;
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] f, input int p,
                                input logic signed [WORD_W-1:0] v);
        while (!quiet && $urandom_range(0, 99) < 25)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= f;
        req_if.position   <= POS_W'(p);
        req_if.item_value <= v;
        do
            @(posedge clk);
        while (!req_if.ready);
        track_length(f, POS_W'(p));
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left     = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request  = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int  n;
        int  roll;
        int  pick;
        int  insert_cut;
        int  p;
        bit  growing;
        logic [FUNC_W-1:0] f;

        rst_n              = 1'b0;
        quiet              = 1'b0;
        hold_request       = 1'b0;
        shadow_len         = 0;
        growing            = 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= FN_CLEAR;
        req_if.position   <= '0;
        req_if.item_value <= '0;
        value_pool[0] = 32'sh7fffffff;
        value_pool[1] = 32'sh80000000;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (n = 4; n < 16; n++)
            value_pool[n] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // refusals on an empty list
        send_request(FN_DELETE, 1, 32'sd5);
        send_request(FN_LOCATE, 0, 32'sd0);
        send_request(FN_INSERT, 0, 32'sd9);
        send_request(FN_INSERT, 2, 32'sd9);
        send_request(FN_INSERT, 129, 32'sd9);
        // front, append and middle inserts with extreme words
        send_request(FN_INSERT, 1, 32'sh7fffffff);
        send_request(FN_INSERT, 1, 32'sh80000000);
        send_request(FN_INSERT, 3, -32'sd1);
        send_request(FN_INSERT, 2, 32'sd0);
        send_request(FN_LOCATE, 0, 32'sh80000000);
        send_request(FN_LOCATE, 255, -32'sd1);
        send_request(FN_LOCATE, 0, 32'sd12345);
        send_request(FN_DELETE, 5, 32'sd0);
        send_request(FN_DELETE, 0, 32'sd0);
        send_request(FN_DELETE, 4, 32'sd0);
        send_request(FN_DELETE, 1, 32'sd0);
        // duplicates: locate reports the first one
        send_request(FN_INSERT, 3, 32'sd7);
        send_request(FN_INSERT, 1, 32'sd7);
        send_request(FN_LOCATE, 0, 32'sd7);
        // clear keeps the words but they are gone from the list
        send_request(FN_CLEAR, 129, 32'sh7fffffff);
        send_request(FN_LOCATE, 0, 32'sd7);
        send_request(FN_DELETE, 1, 32'sd0);
        drain_results();

        // fill to capacity, then refusals, a locate and a tail delete on a full list
        while (shadow_len < CAPACITY)
            send_request(FN_INSERT, $urandom_range(1, shadow_len + 1), pick_word());
        send_request(FN_INSERT, 129, 32'sd1);
        send_request(FN_INSERT, 1, 32'sd1);
        send_request(FN_INSERT, 0, 32'sd1);
        send_request(FN_LOCATE, 0, value_pool[$urandom_range(0, 15)]);
        send_request(FN_DELETE, 129, 32'sd0);
        send_request(FN_DELETE, 128, 32'sd0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                growing = !growing;
            if (n == 350)
                hold_request = 1'b1;
            if (n == 600)
                drain_results();
            quiet = (n >= 700 && n < 900);
            roll  = $urandom_range(0, 99);
            if (roll < 12)
            begin
                f = FUNC_W'($urandom_range(0, 3));
                p = $urandom_range(0, 129);
            end
            else
            begin
                pick       = $urandom_range(0, 99);
                insert_cut = growing ? 71 : 21;
                p          = 0;
                if (pick < 1)
                    f = FN_CLEAR;
                else if (pick < insert_cut || (pick < 84 && shadow_len == 0))
                    f = FN_INSERT;
                else if (pick < 84)
                    f = FN_DELETE;
                else
                    f = FN_LOCATE;
                if (f == FN_INSERT)
                    p = $urandom_range(1, shadow_len + 1);
                else if (f == FN_DELETE)
                    p = $urandom_range(1, shadow_len);
                else
                    p = $urandom_range(0, 129);
            end
            send_request(f, p, pick_word());
        end
        req_if.valid <= 1'b0;
        quiet = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/oale_pkg.sv
design/oale_if.sv
design/oale_out_buf.sv
design/ordered_array_list_engine_unit.sv
verif/list_result_checker.sv
verif/ordered_array_list_engine_unit_tb.sv
